@@ rtl/core/mfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mfp_pkg;

   // size bound of one payload, bytes past it are not examined
   localparam int MAX_PACKET_BYTES = 32;
   localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

   localparam logic [7:0] HDR_MAIN    = 8'hAA;
   localparam logic [7:0] HDR_ALT     = 8'h7E;
   localparam logic [7:0] TAIL_MARK   = 8'h55;
   localparam logic [7:0] TYPE_MOTION = 8'h01;

   // header offset codes, the middle two are the data start itself
   localparam logic [1:0] HOFF_UNDECIDED = 2'd0;
   localparam logic [1:0] HOFF_ONE       = 2'd1;
   localparam logic [1:0] HOFF_TWO       = 2'd2;
   localparam logic [1:0] HOFF_NONE      = 2'd3;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_HEADER  = 3'd1,
      ST_NO_TAIL    = 3'd2,
      ST_TOO_CLOSE  = 3'd3,
      ST_MISMATCH   = 3'd4,
      ST_WRONG_TYPE = 3'd5,
      ST_TOO_SHORT  = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         device_id;
      logic signed [15:0] linear_velocity;
      logic signed [15:0] angular_velocity;
      logic signed [15:0] linear_accel;
      logic signed [15:0] angular_accel;
      logic [7:0]         sequence_number;
   } rsp_payload_type;

endpackage

`default_nettype wire

@@ rtl/core/motion_frame_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// motion frame parser: takes one payload byte per request, with last_byte
// marking the end of the payload, and gives one response per payload on its
// last byte. the response carries a status (ok, no header, no tail, checksum
// too close, mismatch, wrong type, too short) and, when ok, the device id, the
// four little-endian signed 16-bit motion values and the sequence number;
// these fields are zero for any other status. the header is 0xAA 0x7E or
// either byte alone, the tail is the first 0x55 at or after the data start,
// and the byte before the tail must be the 8-bit sum of the bytes from the
// data start up to it. bytes beyond mfp_pkg::MAX_PACKET_BYTES are ignored but
// their last_byte flag still closes the payload. throughput is one byte per
// clock: a byte is held in the request register, the frame state and the
// response are computed by a single compare/8-bit-add stage, and the response
// is loaded into the output register when the last byte is processed out of
// the request register. a stalled response blocks only a last byte behind it.
module motion_frame_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire mfp_pkg::req_payload_type req_payload,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      mfp_pkg::rsp_payload_type rsp_payload
);

   localparam int POS_W = mfp_pkg::POS_W;
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(mfp_pkg::MAX_PACKET_BYTES);

   // request register
   logic                     req_vld_ff;
   mfp_pkg::req_payload_type req_ff;

   // frame state
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [1:0]          hoff_ff, hoff_in;
   logic                tail_ff, tail_in;
   mfp_pkg::status_type chk_ff, chk_in;
   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          prev_ff, prev_in;
   logic [7:0]          type_ff, type_in;
   logic [7:0]          dev_ff, dev_in;
   logic [15:0]         lv_ff, lv_in;
   logic [15:0]         av_ff, av_in;
   logic [15:0]         la_ff, la_in;
   logic [15:0]         aa_ff, aa_in;
   logic [7:0]          seq_ff, seq_in;

   // response register
   logic                     rsp_vld_ff;
   mfp_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic proc_go;
   logic examine_en;
   logic [POS_W-1:0] off;
   logic [POS_W-1:0] rel;
   logic [7:0] b;
   mfp_pkg::status_type status;

   assign b = req_ff.byte_value;

   // a byte without last_byte never needs the response register
   assign proc_go   = req_vld_ff && (!req_ff.last_byte || !rsp_vld_ff || !rsp_stall);
   assign req_stall = req_vld_ff && !proc_go;

   // per-byte frame update
   always_comb begin
      pos_in  = pos_ff;
      hoff_in = hoff_ff;
      tail_in = tail_ff;
      chk_in  = chk_ff;
      sum_in  = sum_ff;
      prev_in = prev_ff;
      type_in = type_ff;
      dev_in  = dev_ff;
      lv_in   = lv_ff;
      av_in   = av_ff;
      la_in   = la_ff;
      aa_in   = aa_ff;
      seq_in  = seq_ff;
      examine_en = 1'b0;

      if (pos_ff < MAX_POS) begin
         if (pos_ff == '0) begin
            // header decision from the first byte
            if (b == mfp_pkg::HDR_MAIN) begin
               hoff_in = mfp_pkg::HOFF_UNDECIDED;
            end else if (b == mfp_pkg::HDR_ALT) begin
               hoff_in = mfp_pkg::HOFF_ONE;
            end else begin
               hoff_in = mfp_pkg::HOFF_NONE;
            end
         end else if (hoff_ff == mfp_pkg::HOFF_UNDECIDED) begin
            // 0xAA seen, a following 0x7E extends the header
            if (b == mfp_pkg::HDR_ALT) begin
               hoff_in = mfp_pkg::HOFF_TWO;
            end else begin
               hoff_in    = mfp_pkg::HOFF_ONE;
               examine_en = 1'b1;
            end
         end else if (hoff_ff != mfp_pkg::HOFF_NONE) begin
            examine_en = 1'b1;
         end
         pos_in = pos_ff + POS_W'(1);
      end

      off = POS_W'(hoff_in);
      rel = pos_ff - off;

      if (examine_en && pos_ff >= off) begin
         // field capture by position after the data start
         if (rel == POS_W'(0)) begin
            type_in = b;
         end else if (rel == POS_W'(1)) begin
            dev_in = b;
         end else if (rel <= POS_W'(3)) begin
            lv_in = rel[0] ? {b, lv_ff[7:0]} : {lv_ff[15:8], b};
         end else if (rel <= POS_W'(5)) begin
            av_in = rel[0] ? {b, av_ff[7:0]} : {av_ff[15:8], b};
         end else if (rel <= POS_W'(7)) begin
            la_in = rel[0] ? {b, la_ff[7:0]} : {la_ff[15:8], b};
         end else if (rel <= POS_W'(9)) begin
            aa_in = rel[0] ? {b, aa_ff[7:0]} : {aa_ff[15:8], b};
         end else if (rel == POS_W'(10)) begin
            seq_in = b;
         end

         // tail search and checksum verdict
         if (!tail_ff) begin
            if (b == mfp_pkg::TAIL_MARK) begin
               tail_in = 1'b1;
               if (pos_ff <= off + POS_W'(1)) begin
                  chk_in = mfp_pkg::ST_TOO_CLOSE;
               end else if (sum_ff != prev_ff) begin
                  chk_in = mfp_pkg::ST_MISMATCH;
               end else begin
                  chk_in = mfp_pkg::ST_OK;
               end
            end else begin
               if (pos_ff > off) begin
                  sum_in = sum_ff + prev_ff;
               end
               prev_in = b;
            end
         end
      end
   end

   // status in priority order, from the updated state
   always_comb begin
      if (hoff_in == mfp_pkg::HOFF_NONE) begin
         status = mfp_pkg::ST_NO_HEADER;
      end else if (hoff_in == mfp_pkg::HOFF_UNDECIDED || !tail_in) begin
         status = mfp_pkg::ST_NO_TAIL;
      end else if (chk_in != mfp_pkg::ST_OK) begin
         status = chk_in;
      end else if (type_in != mfp_pkg::TYPE_MOTION) begin
         status = mfp_pkg::ST_WRONG_TYPE;
      end else if (pos_in <= POS_W'(hoff_in) + POS_W'(10)) begin
         status = mfp_pkg::ST_TOO_SHORT;
      end else begin
         status = mfp_pkg::ST_OK;
      end

      rsp_in = '0;
      rsp_in.status = status;
      if (status == mfp_pkg::ST_OK) begin
         rsp_in.device_id        = dev_in;
         rsp_in.linear_velocity  = lv_in;
         rsp_in.angular_velocity = av_in;
         rsp_in.linear_accel     = la_in;
         rsp_in.angular_accel    = aa_in;
         rsp_in.sequence_number  = seq_in;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         req_vld_ff <= 1'b1;
      end else if (proc_go) begin
         req_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_payload;
      end
   end

   // frame control state, cleared again after each last byte
   always_ff @(posedge clock) begin
      if (reset || (proc_go && req_ff.last_byte)) begin
         pos_ff  <= '0;
         hoff_ff <= mfp_pkg::HOFF_UNDECIDED;
         tail_ff <= 1'b0;
         chk_ff  <= mfp_pkg::ST_OK;
         sum_ff  <= '0;
         prev_ff <= '0;
         type_ff <= '0;
      end else if (proc_go) begin
         pos_ff  <= pos_in;
         hoff_ff <= hoff_in;
         tail_ff <= tail_in;
         chk_ff  <= chk_in;
         sum_ff  <= sum_in;
         prev_ff <= prev_in;
         type_ff <= type_in;
      end
   end

   // captured fields, all rewritten before any ok status can show them
   always_ff @(posedge clock) begin
      if (proc_go) begin
         dev_ff <= dev_in;
         lv_ff  <= lv_in;
         av_ff  <= av_in;
         la_ff  <= la_in;
         aa_ff  <= aa_in;
         seq_ff <= seq_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (proc_go && req_ff.last_byte) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_go && req_ff.last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
